@@ rtl/mstt_pkg.sv @@
// Shared types and constants for the multi software timer table.
// Used by mstt_dp, mstt_ctrl and multi_software_timer_table.
package mstt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int ID_W       = 4;
    localparam int TICK_W     = 32;
    localparam int PER_W      = TICK_W - 1;
    localparam int ORD_W      = 16;
    localparam int MAX_OUT    = 16;

    localparam logic [TICK_W-1:0] TICK_ALL  = '1;
    localparam logic [TICK_W-1:0] HALF_TICK = TICK_ALL >> 1;
    localparam logic [TICK_W-1:0] SIGN_BIT  = HALF_TICK + TICK_W'(1);

    localparam logic [3:0] K_TICK     = 4'd0;
    localparam logic [3:0] K_START    = 4'd1;
    localparam logic [3:0] K_STOP     = 4'd2;
    localparam logic [3:0] K_SETPER   = 4'd3;
    localparam logic [3:0] K_GETPER   = 4'd4;
    localparam logic [3:0] K_ONESHOT  = 4'd5;
    localparam logic [3:0] K_PERIODIC = 4'd6;
    localparam logic [3:0] K_GETSTATE = 4'd7;
    localparam logic [3:0] K_NEAREST  = 4'd8;
    localparam logic [3:0] K_INIT     = 4'd9;

    localparam logic [1:0] EV_EXPIRED = 2'd0;
    localparam logic [1:0] EV_ACK     = 2'd1;
    localparam logic [1:0] EV_DATA    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_STOPPED = 2'd1;
    localparam logic [1:0] ST_TOOBIG  = 2'd2;

    typedef struct packed {
        logic [3:0]        kind;
        logic [ID_W-1:0]   timer_id;
        logic [31:0]       value;
        logic              periodic_mode;
    } t_in;

    typedef struct packed {
        logic [1:0]        event_res;
        logic [ID_W-1:0]   expired_id;
        logic [31:0]       read_data;
        logic [1:0]        status;
        logic              last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic              cap;
        logic              tick_inc;
        logic              due_eval;
        logic              sel_clr;
        logic              sel_eval;
        logic              sel_active;
        logic              fire;
        logic              exec;
        logic              near_out;
        logic              ack_out;
        logic              last;
        logic [ID_W-1:0]   idx;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic              best_vld;
        logic              rem_any;
        logic              out_free;
    } t_stat;

endpackage

@@ rtl/mstt_dp.sv @@
// Datapath of the timer table: timer entries, tick, selection registers
// and the output register. Depends on mstt_pkg; driven by mstt_ctrl.
module mstt_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mstt_pkg::t_in  i_item,
    input  mstt_pkg::t_cmd i_cmd,
    input  logic           i_out_stall,
    output mstt_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output mstt_pkg::t_out o_out_data
);
    import mstt_pkg::*;

    t_in                r_item;
    logic [TICK_W-1:0]  r_tick;
    logic [TICK_W-1:0]  r_deadline [NUM_TIMERS];
    logic [PER_W-1:0]   r_period   [NUM_TIMERS];
    logic [ORD_W-1:0]   r_order    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_active, r_periodic, r_due;
    logic [ORD_W-1:0]   r_cnt;
    logic               r_bvld;
    logic [ID_W-1:0]    r_best;
    logic [TICK_W-1:0]  r_brank, r_bdl;
    logic [ORD_W-1:0]   r_bage;
    logic               r_ovalid;
    t_out               r_out;

    logic [ID_W-1:0]    addr;
    logic [TICK_W-1:0]  dl, rank, arm_dl;
    logic [PER_W-1:0]   pr, clip;
    logic [ORD_W-1:0]   age, cnt_inc;
    logic               arm_ok, big, cand, better, emit;
    t_out               n_out;

    always_comb begin
        if (i_cmd.fire)
            addr = r_best;
        else if (i_cmd.exec)
            addr = r_item.timer_id;
        else
            addr = i_cmd.idx;
    end

    assign dl      = r_deadline[addr];
    assign pr      = r_period[addr];
    assign rank    = (dl - r_tick) ^ SIGN_BIT;
    assign age     = r_cnt - r_order[addr];
    assign arm_ok  = ~(&pr);
    assign arm_dl  = r_tick + {1'b0, pr};
    assign cnt_inc = r_cnt + ORD_W'(1);
    assign big     = r_item.value >= HALF_TICK;
    assign clip    = big ? HALF_TICK[PER_W-1:0] : r_item.value[PER_W-1:0];
    assign cand    = i_cmd.sel_active ? r_active[addr] : r_due[addr];
    // ties go to the older start only when ordering expiries
    assign better  = !r_bvld || rank < r_brank ||
                     (!i_cmd.sel_active && rank == r_brank && age > r_bage);
    assign emit    = i_cmd.exec | i_cmd.fire | i_cmd.near_out | i_cmd.ack_out;

    always_comb begin
        n_out = '0;
        n_out.last = i_cmd.last;
        priority if (i_cmd.fire) begin
            n_out.event_res  = EV_EXPIRED;
            n_out.expired_id = r_best;
            n_out.status     = (r_periodic[r_best] && !arm_ok) ? ST_TOOBIG : ST_OK;
        end else if (i_cmd.near_out) begin
            n_out.event_res = EV_DATA;
            n_out.read_data = r_bvld ? r_bdl : TICK_ALL;
        end else if (i_cmd.ack_out) begin
            n_out.event_res = EV_ACK;
        end else begin
            n_out.expired_id = r_item.timer_id;
            n_out.event_res  = EV_ACK;
            unique case (r_item.kind)
                K_START:    n_out.status = arm_ok ? ST_OK : ST_TOOBIG;
                K_STOP:     n_out.status = r_active[addr] ? ST_OK : ST_STOPPED;
                K_SETPER,
                K_INIT:     n_out.status = big ? ST_TOOBIG : ST_OK;
                K_GETPER: begin
                    n_out.event_res = EV_DATA;
                    n_out.read_data = {1'b0, pr};
                end
                K_GETSTATE: begin
                    n_out.event_res = EV_DATA;
                    n_out.read_data = {31'd0, r_active[addr]};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap)
            r_item <= i_item;
        if (emit)
            r_out <= n_out;
        if (i_cmd.sel_eval && cand && better) begin
            r_best  <= addr;
            r_brank <= rank;
            r_bage  <= age;
            r_bdl   <= dl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_cnt      <= '0;
            r_active   <= '0;
            r_periodic <= '0;
            r_due      <= '0;
            r_bvld     <= 1'b0;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_deadline[i] <= '0;
                r_period[i]   <= '0;
                r_order[i]    <= '0;
            end
        end else begin
            r_ovalid <= emit | (r_ovalid & i_out_stall);
            if (i_cmd.tick_inc)
                r_tick <= r_tick + TICK_W'(1);
            if (i_cmd.due_eval)
                r_due[addr] <= r_active[addr] && ((r_tick - dl) < HALF_TICK);
            if (i_cmd.sel_clr)
                r_bvld <= 1'b0;
            else if (i_cmd.sel_eval && cand)
                r_bvld <= 1'b1;
            if (i_cmd.fire) begin
                r_due[addr] <= 1'b0;
                if (r_periodic[addr] && arm_ok) begin
                    r_deadline[addr] <= arm_dl;
                    r_cnt            <= cnt_inc;
                    r_order[addr]    <= cnt_inc;
                end else begin
                    r_active[addr] <= 1'b0;
                end
            end
            if (i_cmd.exec) begin
                unique case (r_item.kind)
                    K_START: begin
                        if (arm_ok) begin
                            r_deadline[addr] <= arm_dl;
                            r_cnt            <= cnt_inc;
                            r_order[addr]    <= cnt_inc;
                            r_active[addr]   <= 1'b1;
                        end else begin
                            r_active[addr] <= 1'b0;
                        end
                    end
                    K_STOP:     r_active[addr]   <= 1'b0;
                    K_SETPER:   r_period[addr]   <= clip;
                    K_ONESHOT:  r_periodic[addr] <= 1'b0;
                    K_PERIODIC: r_periodic[addr] <= 1'b1;
                    K_INIT: begin
                        r_periodic[addr] <= r_item.periodic_mode;
                        r_active[addr]   <= 1'b0;
                        r_deadline[addr] <= '0;
                        r_period[addr]   <= clip;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_stat.best_vld = r_bvld;
    assign o_stat.rem_any  = |(r_due & ~(NUM_TIMERS'(1) << r_best));
    assign o_stat.out_free = !r_ovalid || !i_out_stall;
    assign o_out_valid     = r_ovalid;
    assign o_out_data      = r_out;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_ovalid || !i_out_stall))
        else $error("result loaded while output register busy");
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.exec, i_cmd.fire, i_cmd.near_out, i_cmd.ack_out}))
        else $error("two result sources in one cycle");
    a_fire_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire |-> (r_bvld && r_due[r_best] && r_active[r_best]))
        else $error("expiry of a timer that is not due");
endmodule

@@ rtl/mstt_ctrl.sv @@
// Sequencer of the timer table: takes items, runs the due and selection
// scans one entry per cycle and paces results. Depends on mstt_pkg.
module mstt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [3:0]      i_kind,
    input  mstt_pkg::t_stat i_stat,
    output logic            o_in_stall,
    output mstt_pkg::t_cmd  o_cmd
);
    import mstt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EXEC = 8'b0000_0010,
        S_DUE  = 8'b0000_0100,
        S_SEL  = 8'b0000_1000,
        S_FIRE = 8'b0001_0000,
        S_ACK  = 8'b0010_0000,
        S_NEAR = 8'b0100_0000,
        S_NOUT = 8'b1000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [ID_W-1:0] r_idx, n_idx;
    logic [3:0]      r_n, n_n;
    logic            scan_end;

    assign scan_end = (r_idx == ID_W'(NUM_TIMERS - 1));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_n     = r_n;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_idx = '0;
                    n_n   = '0;
                    if (i_kind == K_TICK) begin
                        o_cmd.tick_inc = 1'b1;
                        n_state = S_DUE;
                    end else if (i_kind == K_NEAREST) begin
                        o_cmd.sel_clr = 1'b1;
                        n_state = S_NEAR;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DUE: begin
                o_cmd.due_eval = 1'b1;
                n_idx = r_idx + ID_W'(1);
                if (scan_end) begin
                    o_cmd.sel_clr = 1'b1;
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                o_cmd.sel_eval = 1'b1;
                n_idx = r_idx + ID_W'(1);
                if (scan_end)
                    n_state = S_FIRE;
            end
            S_FIRE: begin
                if (!i_stat.best_vld) begin
                    n_state = S_ACK;
                end else if (i_stat.out_free) begin
                    o_cmd.fire = 1'b1;
                    o_cmd.last = !i_stat.rem_any || (r_n == 4'(MAX_OUT - 1));
                    n_n = r_n + 4'd1;
                    o_cmd.sel_clr = 1'b1;
                    n_state = o_cmd.last ? S_IDLE : S_SEL;
                end
            end
            S_ACK: begin
                if (i_stat.out_free) begin
                    o_cmd.ack_out = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_NEAR: begin
                o_cmd.sel_eval   = 1'b1;
                o_cmd.sel_active = 1'b1;
                n_idx = r_idx + ID_W'(1);
                if (scan_end)
                    n_state = S_NOUT;
            end
            S_NOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.near_out = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_n     <= n_n;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state != S_IDLE) |=> (r_idx == '0))
        else $error("scan does not start at entry zero");
    a_fire_after_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIRE) |-> ($past(r_state) == S_SEL || $past(r_state) == S_FIRE))
        else $error("expiry without a selection scan");
    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.last |=> (r_state == S_IDLE))
        else $error("final result did not end the item");
endmodule

@@ rtl/multi_software_timer_table.sv @@
// Software timer table, top level: joins mstt_ctrl and mstt_dp.
// Depends on mstt_pkg.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries commands:
// tick, start, stop, set/get period, one-shot, periodic, get state,
// nearest deadline, init. Output channel (o_out_valid / i_out_stall /
// o_out_data) returns one result per command, or one expiry per due timer
// for a tick; the field last marks the final result of a command.
// One command is processed at a time; o_in_stall is high while it runs.
// Simple commands are executed once the output register is free.
// Nearest deadline scans the table one entry a cycle, then gives its result.
// A tick scans due marks, then runs a selection scan over all entries
// before each expiry, each expiry going out once the output register is free;
// a tick with nothing due is acknowledged after its first selection scan.
// The output register frees as soon as its result is taken; while the
// receiver stalls, the sequencer holds before loading the next result.
// Reset clears the tick, all timers and both channels' valid state.
module multi_software_timer_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mstt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mstt_pkg::t_out o_out_data
);
    import mstt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mstt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    mstt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );
endmodule
